// ===== rtl/bced_pkg.sv =====
package bced_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 8;
   localparam logic [7:0]  HoldLimit     = 8'hFF;

   localparam logic [7:0] DebounceTicksReset     = 8'd2;
   localparam logic [7:0] LongTicksReset         = 8'd50;
   localparam logic [7:0] RepeatTicksReset       = 8'd10;
   localparam logic [7:0] DoubleWindowTicksReset = 8'd15;
   localparam logic       ActiveLevelReset       = 1'b0;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_DEBOUNCE_TICKS   = 3'd0,
      CSR_LONG_TICKS       = 3'd1,
      CSR_REPEAT_TICKS     = 3'd2,
      CSR_DOUBLE_WINDOW    = 3'd3,
      CSR_ACTIVE_LEVEL     = 3'd4,
      CSR_CONTINUOUS_MODE  = 3'd5,
      CSR_LONG_ON_RELEASE  = 3'd6,
      CSR_SINGLE_DEFERRED  = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_DOWN = 2'd1,
      ST_UP   = 2'd2,
      ST_WAIT = 2'd3
   } press_state_type;

   typedef enum logic [2:0] {
      TR_NONE   = 3'd0,
      TR_DOWN   = 3'd1,
      TR_DOUBLE = 3'd2,
      TR_LONG   = 3'd3,
      TR_CONT   = 3'd4
   } trigger_type;

   typedef enum logic [2:0] {
      EV_CLICK       = 3'd0,
      EV_DOUBLE      = 3'd1,
      EV_LONG        = 3'd2,
      EV_LONG_REL    = 3'd3,
      EV_REPEAT      = 3'd4,
      EV_REPEAT_REL  = 3'd5
   } event_type;

   typedef struct packed {
      logic [7:0] debounce_ticks;
      logic [7:0] long_ticks;
      logic [7:0] repeat_ticks;
      logic [7:0] double_window_ticks;
      logic       active_level;
      logic       continuous_mode;
      logic       long_on_release_mode;
      logic       single_deferred_mode;
   } cfg_type;

   typedef struct packed {
      logic            event_valid;
      event_type       event_code;
      press_state_type press_state;
      trigger_type     last_trigger;
   } result_type;

endpackage

// ===== rtl/button_click_event_detector_top.sv =====
// rsp valid follows the req transfer through the input register, then the result register;
// a stall on rsp_stall can hold a tick in either register.
// Throughput: one scan tick per cycle while rsp_stall is low; the counters and press state
// update in a single pass between the two registers, so back-to-back ticks never wait on each other.
// rsp_stall holds the result register and backs up into req_stall through the input stage.
// Reset (synchronous): config to defaults, press state idle, trigger none, counters zero,
// stable level at the inactive level.
module button_click_event_detector_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_pin_level,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_event_valid,
   output logic [2:0]                           rsp_event_code,
   output logic [1:0]                           rsp_press_state,
   output logic [2:0]                           rsp_last_trigger,
   input  logic                                 csr_write_enable,
   input  logic [bced_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [bced_pkg::CsrDataWidth-1:0]    csr_write_data
);
   import bced_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff,  in_valid_in;
   logic       in_level_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       advance;
   logic       req_xfer;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_level_ff <= req_pin_level;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   bced_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   bced_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .level  (in_level_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_valid  = out_ff.event_valid;
   assign rsp_event_code   = out_ff.event_code;
   assign rsp_press_state  = out_ff.press_state;
   assign rsp_last_trigger = out_ff.last_trigger;

endmodule

// ===== rtl/bced_csr.sv =====
module bced_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [bced_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [bced_pkg::CsrDataWidth-1:0]    csr_write_data,
   output bced_pkg::cfg_type                    cfg
);
   import bced_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE_TICKS:  cfg_in.debounce_ticks       = csr_write_data;
            CSR_LONG_TICKS:      cfg_in.long_ticks           = csr_write_data;
            CSR_REPEAT_TICKS:    cfg_in.repeat_ticks         = csr_write_data;
            CSR_DOUBLE_WINDOW:   cfg_in.double_window_ticks  = csr_write_data;
            CSR_ACTIVE_LEVEL:    cfg_in.active_level         = csr_write_data[0];
            CSR_CONTINUOUS_MODE: cfg_in.continuous_mode      = csr_write_data[0];
            CSR_LONG_ON_RELEASE: cfg_in.long_on_release_mode = csr_write_data[0];
            CSR_SINGLE_DEFERRED: cfg_in.single_deferred_mode = csr_write_data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks       <= DebounceTicksReset;
         cfg_ff.long_ticks           <= LongTicksReset;
         cfg_ff.repeat_ticks         <= RepeatTicksReset;
         cfg_ff.double_window_ticks  <= DoubleWindowTicksReset;
         cfg_ff.active_level         <= ActiveLevelReset;
         cfg_ff.continuous_mode      <= 1'b0;
         cfg_ff.long_on_release_mode <= 1'b0;
         cfg_ff.single_deferred_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/bced_core.sv =====
module bced_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  level,
   input  bced_pkg::cfg_type     cfg,
   output bced_pkg::result_type  result
);
   import bced_pkg::*;

   logic            stable_ff,   stable_in;
   logic [7:0]      debounce_ff, debounce_in;
   press_state_type state_ff,    state_in;
   trigger_type     prev_ff,     prev_in;
   trigger_type     trigger_ff,  trigger_in;
   logic [7:0]      hold_ff,     hold_in;
   logic [7:0]      repeat_ff,   repeat_in;
   logic [7:0]      window_ff,   window_in;
   logic            fire;
   event_type       code;

   always_comb begin
      stable_in   = stable_ff;
      debounce_in = debounce_ff;
      state_in    = state_ff;
      prev_in     = prev_ff;
      trigger_in  = trigger_ff;
      hold_in     = hold_ff;
      repeat_in   = repeat_ff;
      window_in   = window_ff;
      fire        = 1'b0;
      code        = EV_CLICK;

      // debounce: count accumulates over differing ticks, cleared only on accept
      if (level != stable_ff) begin
         debounce_in = debounce_ff + 8'd1;
         if (debounce_in >= cfg.debounce_ticks) begin
            stable_in   = level;
            debounce_in = 8'd0;
            if (state_ff == ST_IDLE || state_ff == ST_WAIT) begin
               state_in = ST_DOWN;
            end else if (state_ff == ST_DOWN) begin
               state_in = ST_UP;
            end
         end
      end

      case (state_in)
         ST_DOWN: begin
            if (stable_in == cfg.active_level) begin
               if (cfg.continuous_mode) begin
                  repeat_in = repeat_ff + 8'd1;
                  if (repeat_in >= cfg.repeat_ticks) begin
                     repeat_in  = 8'd0;
                     trigger_in = TR_CONT;
                     fire       = 1'b1;
                     code       = EV_REPEAT;
                  end
               end else begin
                  trigger_in = TR_DOWN;
                  hold_in    = hold_ff + 8'd1;
                  if (hold_in >= cfg.long_ticks) begin
                     if (cfg.long_on_release_mode) begin
                        trigger_in = TR_LONG;
                     end else begin
                        repeat_in = repeat_ff + 8'd1;
                        if (repeat_in >= cfg.repeat_ticks) begin
                           repeat_in  = 8'd0;
                           trigger_in = TR_LONG;
                           fire       = 1'b1;
                           code       = EV_LONG;
                        end
                     end
                     // saturate back to the long threshold
                     if (hold_in == HoldLimit) begin
                        hold_in = cfg.long_ticks;
                     end
                  end
               end
            end
         end
         ST_UP: begin
            if (trigger_ff == TR_DOWN) begin
               if (window_ff <= cfg.double_window_ticks && prev_ff == TR_DOUBLE) begin
                  trigger_in = TR_DOUBLE;
                  fire       = 1'b1;
                  code       = EV_DOUBLE;
                  state_in   = ST_IDLE;
                  prev_in    = TR_NONE;
               end else begin
                  window_in = 8'd0;
                  hold_in   = 8'd0;
                  if (!cfg.single_deferred_mode) begin
                     fire = 1'b1;
                     code = EV_CLICK;
                  end
                  state_in = ST_WAIT;
                  prev_in  = TR_DOUBLE;
               end
            end else if (trigger_ff == TR_LONG) begin
               fire     = 1'b1;
               code     = cfg.long_on_release_mode ? EV_LONG : EV_LONG_REL;
               hold_in  = 8'd0;
               state_in = ST_IDLE;
               prev_in  = TR_LONG;
            end else if (cfg.continuous_mode && trigger_ff == TR_CONT) begin
               hold_in  = 8'd0;
               fire     = 1'b1;
               code     = EV_REPEAT_REL;
               state_in = ST_IDLE;
               prev_in  = TR_CONT;
            end
         end
         ST_WAIT: begin
            window_in = window_ff + 8'd1;
            if (window_in >= cfg.double_window_ticks) begin
               state_in = ST_IDLE;
               prev_in  = TR_NONE;
               if (cfg.single_deferred_mode) begin
                  window_in = 8'd0;
                  fire      = 1'b1;
                  code      = EV_CLICK;
                  prev_in   = TR_DOWN;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff   <= ~ActiveLevelReset;
         debounce_ff <= 8'd0;
         state_ff    <= ST_IDLE;
         prev_ff     <= TR_NONE;
         trigger_ff  <= TR_NONE;
         hold_ff     <= 8'd0;
         repeat_ff   <= 8'd0;
         window_ff   <= 8'd0;
      end else if (step) begin
         stable_ff   <= stable_in;
         debounce_ff <= debounce_in;
         state_ff    <= state_in;
         prev_ff     <= prev_in;
         trigger_ff  <= trigger_in;
         hold_ff     <= hold_in;
         repeat_ff   <= repeat_in;
         window_ff   <= window_in;
      end
   end

   assign result.event_valid  = fire;
   assign result.event_code   = fire ? code : EV_CLICK;
   assign result.press_state  = state_in;
   assign result.last_trigger = trigger_in;

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(state_ff) && $stable(trigger_ff) && $stable(debounce_ff))
      else $error("core state moved without a transfer");

   a_no_idle_to_up: assert property (@(posedge clock) disable iff (reset)
      step && state_ff == ST_IDLE |-> state_in != ST_UP)
      else $error("idle jumped straight to up");

   a_double_ends_idle: assert property (@(posedge clock) disable iff (reset)
      step && fire && code == EV_DOUBLE |=> state_ff == ST_IDLE && trigger_ff == TR_DOUBLE)
      else $error("double click did not return to idle");

   a_hold_bounded: assert property (@(posedge clock) disable iff (reset)
      step && state_in == ST_DOWN && !cfg.continuous_mode
         && stable_in == cfg.active_level |-> hold_in != HoldLimit)
      else $error("hold count left at its limit");

endmodule
